// ----- hw/rtl/abdq_pkg.sv -----
// ----------------------------------------------------------------------------
// abdq_pkg
// shared types and constants of the area burst detection qualifier
// ----------------------------------------------------------------------------
package abdq_pkg;

    localparam int MASK_BITS = 16;

    localparam logic       CMD_TICK   = 1'b0;
    localparam logic       CMD_REPORT = 1'b1;

    localparam logic [1:0] OUTCOME_NONE      = 2'd0;
    localparam logic [1:0] OUTCOME_FRONT     = 2'd1;
    localparam logic [1:0] OUTCOME_BACK      = 2'd2;
    localparam logic [1:0] OUTCOME_INHIBITED = 2'd3;

    localparam logic [1:0] REG_WIN_MINUTES         = 2'd0;
    localparam logic [1:0] REG_DETECTION_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_FRONT_AREA          = 2'd2;

    localparam logic [7:0] WIN_MINUTES_RESET         = 8'd5;
    localparam logic [7:0] DETECTION_THRESHOLD_RESET = 8'd3;
    localparam logic [2:0] FRONT_AREA_RESET          = 3'd0;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  area;
        logic [15:0] person_mask;
        logic [4:0]  image_count;
        logic        armed;
    } in_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic       window_restarted;
        logic [7:0] positives_now;
        logic [7:0] expired_areas;
    } out_t;

    typedef struct packed {
        logic        active;
        logic [31:0] window_start;
        logic [7:0]  hit_count;
    } entry_t;

    typedef struct packed {
        logic [13:0] timeout;
        logic [7:0]  threshold;
        logic [2:0]  front_area;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY,
        ST_SWEEP,
        ST_FINISH
    } state_t;

endpackage

// ----- hw/rtl/abdq_ram.sv -----
// ----------------------------------------------------------------------------
// abdq_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module abdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/abdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// abdq_ctrl
// request sequencer: per-area read-modify-write, tick sweep, result register
// ----------------------------------------------------------------------------
module abdq_ctrl #(
    parameter int AREAS             = 8,
    parameter int IMAGES_PER_REPORT = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  abdq_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_stall,
    input  abdq_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output abdq_pkg::out_t out_data
);

    localparam int AW    = AREAS > 1 ? $clog2(AREAS) : 1;
    localparam int LIMIT = IMAGES_PER_REPORT < abdq_pkg::MASK_BITS ?
                           IMAGES_PER_REPORT : abdq_pkg::MASK_BITS;
    localparam logic [AW-1:0] LAST_AREA = AW'(AREAS - 1);

    abdq_pkg::state_t state_reg, state_next;
    logic [31:0]      sec_reg, sec_next;
    logic [AREAS-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [2:0]       area_reg, area_next;
    logic             armed_reg, armed_next;
    logic [4:0]       pop_reg, pop_next;
    logic             nz_reg, nz_next;
    logic [31:0]      base_start_reg, base_start_next;
    logic [7:0]       base_cnt_reg, base_cnt_next;
    logic             restart_reg, restart_next;
    logic [7:0]       expired_reg, expired_next;
    abdq_pkg::out_t   res_reg, res_next;
    logic             out_valid_reg;
    abdq_pkg::out_t   out_data_reg;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    abdq_pkg::entry_t ram_wdata, ram_rdata, entry;

    logic             out_free, out_load;
    logic [4:0]       lim;
    logic [15:0]      low_mask;
    logic             in_range;
    logic [31:0]      age;
    logic [31:0]      timeout32;
    logic [8:0]       sum;
    logic [7:0]       sat;
    logic             trig;

    abdq_ram #(
        .WIDTH ($bits(abdq_pkg::entry_t)),
        .DEPTH (AREAS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry     = rd_valid_reg ? ram_rdata : '0;
    assign timeout32 = {18'd0, cfg.timeout};
    assign age       = sec_reg - entry.window_start;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = state_reg != abdq_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // image count limited to the mask and the report size
    assign lim      = (in_data.image_count > 5'(LIMIT)) ? 5'(LIMIT) : in_data.image_count;
    assign low_mask = 16'((17'd1 << lim) - 17'd1);
    assign in_range = {29'd0, in_data.area} < 32'(AREAS);

    assign sum  = {1'b0, base_cnt_reg} + {4'd0, pop_reg};
    assign sat  = sum[8] ? 8'hFF : sum[7:0];
    assign trig = nz_reg && (sat >= cfg.threshold);

    always_comb
    begin
        state_next      = state_reg;
        sec_next        = sec_reg;
        addr_next       = addr_reg;
        area_next       = area_reg;
        armed_next      = armed_reg;
        pop_next        = pop_reg;
        nz_next         = nz_reg;
        base_start_next = base_start_reg;
        base_cnt_next   = base_cnt_reg;
        restart_next    = restart_reg;
        expired_next    = expired_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;
        out_load        = 1'b0;
        case (state_reg)
            abdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.cmd == abdq_pkg::CMD_TICK)
                    begin
                        sec_next     = sec_reg + 32'd1;
                        ram_re       = 1'b1;
                        ram_raddr    = '0;
                        addr_next    = '0;
                        expired_next = '0;
                        state_next   = abdq_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        area_next  = in_data.area;
                        armed_next = in_data.armed;
                        pop_next   = 5'($countones(in_data.person_mask & low_mask));
                        nz_next    = lim != 5'd0;
                        if (in_range)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(in_data.area);
                            addr_next  = AW'(in_data.area);
                            state_next = abdq_pkg::ST_EVAL;
                        end
                        else
                        begin
                            res_next   = '0;
                            state_next = abdq_pkg::ST_FINISH;
                        end
                    end
                end
            end
            abdq_pkg::ST_EVAL:
            begin
                // idle area opens at the current second, stale window reopens
                if (!entry.active)
                begin
                    base_start_next = sec_reg;
                    base_cnt_next   = 8'd0;
                    restart_next    = 1'b0;
                end
                else if (age > timeout32)
                begin
                    base_start_next = sec_reg;
                    base_cnt_next   = 8'd0;
                    restart_next    = 1'b1;
                end
                else
                begin
                    base_start_next = entry.window_start;
                    base_cnt_next   = entry.hit_count;
                    restart_next    = 1'b0;
                end
                state_next = abdq_pkg::ST_APPLY;
            end
            abdq_pkg::ST_APPLY:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                if (trig)
                begin
                    ram_wdata = '0;
                end
                else
                begin
                    ram_wdata = '{active: 1'b1, window_start: base_start_reg,
                                  hit_count: sat};
                end
                res_next.window_restarted = restart_reg;
                res_next.positives_now    = trig ? 8'd0 : sat;
                res_next.expired_areas    = 8'd0;
                if (!trig)
                begin
                    res_next.outcome = abdq_pkg::OUTCOME_NONE;
                end
                else if (!armed_reg)
                begin
                    res_next.outcome = abdq_pkg::OUTCOME_INHIBITED;
                end
                else if (area_reg == cfg.front_area)
                begin
                    res_next.outcome = abdq_pkg::OUTCOME_FRONT;
                end
                else
                begin
                    res_next.outcome = abdq_pkg::OUTCOME_BACK;
                end
                state_next = abdq_pkg::ST_FINISH;
            end
            abdq_pkg::ST_SWEEP:
            begin
                if (entry.active && (age >= timeout32))
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = addr_reg;
                    ram_wdata    = '0;
                    expired_next = expired_reg | (8'd1 << addr_reg);
                end
                if (addr_reg == LAST_AREA)
                begin
                    res_next   = '{outcome: abdq_pkg::OUTCOME_NONE, window_restarted: 1'b0,
                                   positives_now: 8'd0, expired_areas: expired_next};
                    state_next = abdq_pkg::ST_FINISH;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg + AW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            abdq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = abdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = abdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abdq_pkg::ST_IDLE;
            sec_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        area_reg       <= area_next;
        armed_reg      <= armed_next;
        pop_reg        <= pop_next;
        nz_reg         <= nz_next;
        base_start_reg <= base_start_next;
        base_cnt_reg   <= base_cnt_next;
        restart_reg    <= restart_next;
        expired_reg    <= expired_next;
        res_reg        <= res_next;
        if (ram_re)
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == abdq_pkg::ST_APPLY || state_reg == abdq_pkg::ST_SWEEP))
        else $error("memory write outside apply or sweep");

    a_tick_second: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == abdq_pkg::ST_IDLE && in_valid && in_data.cmd == abdq_pkg::CMD_TICK)
        |=> sec_reg == 32'($past(sec_reg) + 32'd1))
        else $error("tick did not advance the second counter");

    a_sweep_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == abdq_pkg::ST_SWEEP && addr_reg != LAST_AREA)
        |=> (state_reg == abdq_pkg::ST_SWEEP && addr_reg == AW'($past(addr_reg) + AW'(1))))
        else $error("sweep skipped an area");

    a_eval_apply: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == abdq_pkg::ST_EVAL |=> state_reg == abdq_pkg::ST_APPLY)
        else $error("report evaluation not followed by write back");

endmodule

// ----- hw/rtl/area_burst_detection_qualifier_core.sv -----
// ----------------------------------------------------------------------------
// area_burst_detection_qualifier_core
// per-area burst counting of person detections with windowed alarm trigger
// ----------------------------------------------------------------------------
// report: the entry is read, evaluated and written back, then the result is
// registered; an area out of range goes straight to the result
// tick: the sweep walks all AREAS entries, one area a cycle through the state
// memory read port, then registers the mask of expired areas as its result
// one request in flight at a time; a new request is taken while a result waits
// reset clears control state and per-area valid flops; unwritten entries read as zero
// ----------------------------------------------------------------------------
module area_burst_detection_qualifier_core #(
    parameter int AREAS             = 8,
    parameter int IMAGES_PER_REPORT = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  abdq_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output abdq_pkg::out_t out_data
);

    logic [7:0]     win_minutes_reg;
    logic [7:0]     threshold_reg;
    logic [2:0]     front_area_reg;
    abdq_pkg::cfg_t cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_minutes_reg <= abdq_pkg::WIN_MINUTES_RESET;
            threshold_reg   <= abdq_pkg::DETECTION_THRESHOLD_RESET;
            front_area_reg  <= abdq_pkg::FRONT_AREA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abdq_pkg::REG_WIN_MINUTES:         win_minutes_reg <= cfg_data;
                abdq_pkg::REG_DETECTION_THRESHOLD: threshold_reg   <= cfg_data;
                abdq_pkg::REG_FRONT_AREA:          front_area_reg  <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    // minutes times sixty as 64 minus 4
    assign cfg.timeout    = {win_minutes_reg, 6'd0} - {4'd0, win_minutes_reg, 2'd0};
    assign cfg.threshold  = threshold_reg;
    assign cfg.front_area = front_area_reg;

    abdq_ctrl #(
        .AREAS             (AREAS),
        .IMAGES_PER_REPORT (IMAGES_PER_REPORT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- bench/qualifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qualifier_checker
// watches the request and result channels and the register port of the
// qualifier core, keeps its own copy of the per-area windows and counts,
// and compares every returned result field by field with its prediction
// ----------------------------------------------------------------------------
module qualifier_checker #(
    parameter int AREAS             = 8,
    parameter int IMAGES_PER_REPORT = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           in_valid,
    input  logic           in_stall,
    input  abdq_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  abdq_pkg::out_t out_data,
    output int             mismatch_count,
    output int             results_owed
);

    logic        area_open    [AREAS];
    logic [31:0] area_started [AREAS];
    logic [7:0]  area_hits    [AREAS];
    logic [31:0] clock_seconds;
    logic [7:0]  win_minutes;
    logic [7:0]  threshold;
    logic [2:0]  front_area;

    abdq_pkg::out_t expected_results[$];
    abdq_pkg::out_t want;

    function automatic void close_area(input int a);
        area_open[a]    = 1'b0;
        area_started[a] = '0;
        area_hits[a]    = '0;
    endfunction

    function automatic void open_area(input int a);
        area_open[a]    = 1'b1;
        area_started[a] = clock_seconds;
        area_hits[a]    = '0;
    endfunction

    function automatic abdq_pkg::out_t qualify_request(input abdq_pkg::in_t req);
        abdq_pkg::out_t res;
        logic [31:0]    timeout;
        logic [31:0]    age;
        int             a;
        int             i;
        int             images;
        logic           fired;
        res     = '0;
        timeout = {24'd0, win_minutes} * 32'd60;
        if (req.cmd == abdq_pkg::CMD_TICK)
        begin
            clock_seconds = clock_seconds + 32'd1;
            for (a = 0; a < AREAS; a++)
            begin
                age = clock_seconds - area_started[a];
                if (area_open[a] && age >= timeout)
                begin
                    close_area(a);
                    if (a < 8)
                        res.expired_areas[a] = 1'b1;
                end
            end
        end
        else if (int'(req.area) < AREAS)
        begin
            a = int'(req.area);
            if (!area_open[a])
                open_area(a);
            age = clock_seconds - area_started[a];
            if (age > timeout)
            begin
                close_area(a);
                open_area(a);
                res.window_restarted = 1'b1;
            end
            images = int'(req.image_count);
            if (images > IMAGES_PER_REPORT)
                images = IMAGES_PER_REPORT;
            if (images > abdq_pkg::MASK_BITS)
                images = abdq_pkg::MASK_BITS;
            fired = 1'b0;
            for (i = 0; i < images && !fired; i++)
            begin
                if (req.person_mask[i] && area_hits[a] != 8'hFF)
                    area_hits[a] = area_hits[a] + 8'd1;
                if (area_hits[a] >= threshold)
                begin
                    if (req.armed)
                        res.outcome = (req.area == front_area) ? abdq_pkg::OUTCOME_FRONT
                                                               : abdq_pkg::OUTCOME_BACK;
                    else
                        res.outcome = abdq_pkg::OUTCOME_INHIBITED;
                    close_area(a);
                    fired = 1'b1;
                end
            end
            res.positives_now = area_hits[a];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AREAS; a++)
                close_area(a);
            clock_seconds = '0;
            win_minutes   = abdq_pkg::WIN_MINUTES_RESET;
            threshold     = abdq_pkg::DETECTION_THRESHOLD_RESET;
            front_area    = abdq_pkg::FRONT_AREA_RESET;
            expected_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting: outcome %0d positives_now %0d",
                           out_data.outcome, out_data.positives_now);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", want.outcome, out_data.outcome);
                        mismatch_count++;
                    end
                    if (out_data.window_restarted !== want.window_restarted)
                    begin
                        $error("window_restarted: expected %0d, got %0d",
                               want.window_restarted, out_data.window_restarted);
                        mismatch_count++;
                    end
                    if (out_data.positives_now !== want.positives_now)
                    begin
                        $error("positives_now: expected %0d, got %0d",
                               want.positives_now, out_data.positives_now);
                        mismatch_count++;
                    end
                    if (out_data.expired_areas !== want.expired_areas)
                    begin
                        $error("expired_areas: expected %b, got %b",
                               want.expired_areas, out_data.expired_areas);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(qualify_request(in_data));
            if (cfg_we)
            begin
                case (cfg_index)
                    abdq_pkg::REG_WIN_MINUTES:         win_minutes = cfg_data;
                    abdq_pkg::REG_DETECTION_THRESHOLD: threshold = cfg_data;
                    abdq_pkg::REG_FRONT_AREA:          front_area = cfg_data[2:0];
                    default:                           ;
                endcase
            end
        end
        results_owed = expected_results.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives directed and random detection reports and ticks into the qualifier
// core through several register settings, with bursty requests and a
// stalling receiver; the checker beside the core predicts and compares
// ----------------------------------------------------------------------------
module testbench;

    localparam int AREAS             = 8;
    localparam int IMAGES_PER_REPORT = 16;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [1:0]     cfg_index = abdq_pkg::REG_WIN_MINUTES;
    logic [7:0]     cfg_data  = '0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    abdq_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    abdq_pkg::out_t out_data;
    int             mismatch_count;
    int             results_owed;
    int             stall_mode = 0;
    int             stall_left = 0;

    area_burst_detection_qualifier_core #(
        .AREAS             (AREAS),
        .IMAGES_PER_REPORT (IMAGES_PER_REPORT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    qualifier_checker #(
        .AREAS             (AREAS),
        .IMAGES_PER_REPORT (IMAGES_PER_REPORT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #6 clk = ~clk;

    // receiver stall pattern, switching between calm, light, periodic and heavy
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(3);
            stall_left <= $urandom_range(32, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(99) < 30);
            2:       out_stall <= ((stall_left % 5) < 2);
            default: out_stall <= ($urandom_range(99) < 75);
        endcase
    end

    task automatic send(input abdq_pkg::in_t req);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic issue(input logic cmd, input logic [2:0] area, input logic [15:0] mask,
                         input logic [4:0] images, input logic armed);
        abdq_pkg::in_t req;
        req.cmd         = cmd;
        req.area        = area;
        req.person_mask = mask;
        req.image_count = images;
        req.armed       = armed;
        send(req);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
    endtask

    task automatic configure(input logic [7:0] minutes, input logic [7:0] needed,
                             input logic [2:0] front);
        drain_results();
        write_reg(abdq_pkg::REG_WIN_MINUTES, minutes);
        write_reg(abdq_pkg::REG_DETECTION_THRESHOLD, needed);
        write_reg(abdq_pkg::REG_FRONT_AREA, {5'd0, front});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic abdq_pkg::in_t make_request(input int tick_pct, input logic dense);
        abdq_pkg::in_t req;
        req.cmd  = ($urandom_range(99) < tick_pct) ? abdq_pkg::CMD_TICK : abdq_pkg::CMD_REPORT;
        req.area = 3'($urandom_range(7));
        case ($urandom_range(5))
            0:       req.person_mask = 16'($urandom);
            1:       req.person_mask = 16'hFFFF;
            2:       req.person_mask = 16'h0000;
            3:       req.person_mask = 16'h0001 << $urandom_range(15);
            default: req.person_mask = 16'($urandom & $urandom);
        endcase
        if (dense && $urandom_range(9) < 8)
            req.person_mask = 16'hFFFF;
        if ($urandom_range(9) < 2)
            req.image_count = 5'($urandom_range(17, 31));
        else
            req.image_count = 5'($urandom_range(0, 16));
        req.armed = 1'($urandom_range(1));
        return req;
    endfunction

    task automatic run_phase(input logic [7:0] minutes, input logic [7:0] needed,
                             input logic [2:0] front, input int items, input int tick_pct,
                             input logic dense);
        int left;
        int burst;
        int gap;
        configure(minutes, needed, front);
        left = items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0)
            begin
                send(make_request(tick_pct, dense));
                burst--;
                left--;
            end
            gap = $urandom_range(0, 11);
            if (gap == 0)
                drain_results();
            else if (gap >= 4)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 4)
                    @(negedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings: front fire, inhibited, oversized count, zero images
        issue(abdq_pkg::CMD_REPORT, 3'd0, 16'hFFFF, 5'd16, 1'b1);
        issue(abdq_pkg::CMD_REPORT, 3'd3, 16'hFFFF, 5'd0, 1'b0);
        issue(abdq_pkg::CMD_REPORT, 3'd3, 16'hFFFF, 5'd31, 1'b0);
        issue(abdq_pkg::CMD_REPORT, 3'd5, 16'h0001, 5'd1, 1'b1);
        issue(abdq_pkg::CMD_REPORT, 3'd5, 16'h8000, 5'd16, 1'b1);
        issue(abdq_pkg::CMD_REPORT, 3'd4, 16'h8000, 5'd15, 1'b1);
        issue(abdq_pkg::CMD_REPORT, 3'd7, 16'hAAAA, 5'd17, 1'b1);
        issue(abdq_pkg::CMD_REPORT, 3'd2, 16'h0000, 5'd16, 1'b1);
        issue(abdq_pkg::CMD_TICK, 3'd0, 16'h0000, 5'd0, 1'b0);
        issue(abdq_pkg::CMD_TICK, 3'd7, 16'hFFFF, 5'd31, 1'b1);

        // zero timeout and zero threshold: stale window restarts, first image fires
        configure(8'd0, 8'd0, 3'd7);
        issue(abdq_pkg::CMD_REPORT, 3'd2, 16'h0000, 5'd0, 1'b1);
        issue(abdq_pkg::CMD_REPORT, 3'd7, 16'h0000, 5'd1, 1'b1);
        issue(abdq_pkg::CMD_REPORT, 3'd6, 16'h0000, 5'd1, 1'b0);
        issue(abdq_pkg::CMD_REPORT, 3'd1, 16'hFFFF, 5'd16, 1'b1);
        issue(abdq_pkg::CMD_TICK, 3'd0, 16'h0000, 5'd0, 1'b0);
        issue(abdq_pkg::CMD_TICK, 3'd0, 16'h0000, 5'd0, 1'b0);

        configure(8'd255, 8'd255, 3'd0);
        issue(abdq_pkg::CMD_REPORT, 3'd0, 16'hFFFF, 5'd16, 1'b1);
        issue(abdq_pkg::CMD_TICK, 3'd0, 16'h0000, 5'd0, 1'b0);

        run_phase(8'd1, 8'd3, 3'd2, 400, 50, 1'b0);
        run_phase(8'd10, 8'd200, 3'd4, 300, 70, 1'b0);
        run_phase(8'd0, 8'd1, 3'd5, 200, 30, 1'b0);
        run_phase(8'd255, 8'd255, 3'd7, 300, 5, 1'b1);
        run_phase(8'd2, 8'($urandom_range(1, 8)), 3'($urandom_range(7)), 400, 60, 1'b0);
        run_phase(8'($urandom_range(1, 3)), 8'($urandom_range(1, 20)), 3'($urandom_range(7)),
                  300, 55, 1'b0);

        drain_results();
        repeat (AREAS + 4)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("area_burst_detection_qualifier_core: match");
        else
            $display("area_burst_detection_qualifier_core: mismatch");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("area_burst_detection_qualifier_core: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/abdq_pkg.sv
hw/rtl/abdq_ram.sv
hw/rtl/abdq_ctrl.sv
hw/rtl/area_burst_detection_qualifier_core.sv
bench/qualifier_checker.sv
bench/testbench.sv
